// File: hw/rtl/rational_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// rational arithmetic unit assertion macros
// shared property templates for the rational arithmetic unit
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RAU_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RAU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rational arithmetic unit package
// item types, op codes and derived widths
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int RES_NUM_W    = 32;
    localparam int RES_DEN_W    = 31;

    // raw products and magnitudes
    localparam int MAG_W = 2 * OPERAND_BITS;
    localparam int NUM_W = MAG_W + 1;
    localparam int SUB_W = MAG_W + 1;
    localparam int CNT_W = $clog2(MAG_W + 1);
    localparam int EXT_W = (MAG_W + 1 > RES_NUM_W) ? MAG_W + 1 : RES_NUM_W;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        t_op                            op;
        logic signed [OPERAND_BITS-1:0] a_num;
        logic        [OPERAND_BITS-2:0] a_den;
        logic signed [OPERAND_BITS-1:0] b_num;
        logic        [OPERAND_BITS-2:0] b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [RES_NUM_W-1:0] res_num;
        logic        [RES_DEN_W-1:0] res_den;
    } t_out_item;

endpackage

// File: hw/rtl/rau_mul.sv
// ----------------------------------------------------------------------------
// rau multiplier
// signed multiplier with registered product, shared by all cross products
// ----------------------------------------------------------------------------
module rau_mul #(
    parameter int W = rau_pkg::OPERAND_BITS
) (
    input  logic                  i_clk,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_prod
);

    logic signed [2*W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// File: hw/rtl/rau_sub.sv
// ----------------------------------------------------------------------------
// rau subtractor
// unsigned subtract with borrow, shared by gcd and division steps
// ----------------------------------------------------------------------------
module rau_sub #(
    parameter int W = rau_pkg::SUB_W
) (
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    output logic [W-1:0] o_diff,
    output logic         o_borrow
);

    logic [W:0] w_full;

    assign w_full   = {1'b0, i_x} - {1'b0, i_y};
    assign o_diff   = w_full[W-1:0];
    assign o_borrow = w_full[W];

endmodule

// File: hw/rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational arithmetic unit
// add, subtract, multiply or divide two fractions and return the reduced result
// ----------------------------------------------------------------------------
// One item at a time. After an item is taken, the three cross products run
// through one shared multiplier, then signs are normalised. Unless the
// numerator is zero, a binary gcd and two restoring divisions follow, all on
// one shared subtractor, before the result is loaded into the output register.
// The input side is ready again once the result sits in the output register,
// even if it has not yet been taken.
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rau_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rau_pkg::t_out_item  o_out_item
);

    import rau_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MUL0 = 10'b00_0000_0010,
        S_MUL1 = 10'b00_0000_0100,
        S_MUL2 = 10'b00_0000_1000,
        S_MUL3 = 10'b00_0001_0000,
        S_NORM = 10'b00_0010_0000,
        S_GCD  = 10'b00_0100_0000,
        S_DIVN = 10'b00_1000_0000,
        S_DIVD = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

    t_state                    r_state, n_state;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out, n_out;
    t_in_item                  r_in, n_in;
    logic signed [NUM_W-1:0]   r_n, n_n;
    logic signed [MAG_W-1:0]   r_d, n_d;
    logic                      r_neg, n_neg;
    logic        [MAG_W-1:0]   r_mag, n_mag;
    logic        [MAG_W-1:0]   r_den, n_den;
    logic        [MAG_W-1:0]   r_u, n_u;
    logic        [MAG_W-1:0]   r_v, n_v;
    logic        [CNT_W-1:0]   r_k, n_k;
    logic        [MAG_W-1:0]   r_g, n_g;
    logic        [MAG_W-1:0]   r_q, n_q;
    logic        [MAG_W-1:0]   r_r, n_r;
    logic        [CNT_W-1:0]   r_cnt, n_cnt;

    // multiplier operands
    logic signed [OPERAND_BITS-1:0] a_den_s, b_den_s, mul_a, mul_b;
    logic signed [MAG_W-1:0]        prod;

    // subtractor operands
    logic [SUB_W-1:0] sub_x, sub_y, sub_diff, abs_diff;
    logic             sub_borrow;
    logic [MAG_W-1:0] half_diff, step_q, step_r;
    logic             last_step;

    // normalisation
    logic [NUM_W-1:0] num_abs;
    logic [MAG_W-1:0] d_abs, den_norm, mag_norm;

    // result formatting
    logic signed [EXT_W-1:0] mag_ext, res_ext;
    logic        [EXT_W-1:0] den_ext;
    logic                    out_free;

    assign a_den_s = $signed({1'b0, r_in.a_den});
    assign b_den_s = $signed({1'b0, r_in.b_den});

    always_comb begin
        case (r_state)
            S_MUL1: begin
                mul_a = a_den_s;
                mul_b = r_in.b_num;
            end
            S_MUL2: begin
                mul_a = a_den_s;
                mul_b = (r_in.op == OP_DIV) ? r_in.b_num : b_den_s;
            end
            default: begin
                mul_a = r_in.a_num;
                mul_b = (r_in.op == OP_MUL) ? r_in.b_num : b_den_s;
            end
        endcase
    end

    rau_mul #(
        .W      (OPERAND_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    always_comb begin
        case (r_state)
            S_DIVN, S_DIVD: begin
                sub_x = {r_r, r_q[MAG_W-1]};
                sub_y = {1'b0, r_g};
            end
            default: begin
                sub_x = {1'b0, r_u};
                sub_y = {1'b0, r_v};
            end
        endcase
    end

    rau_sub #(
        .W        (SUB_W)
    ) u_sub (
        .i_x      (sub_x),
        .i_y      (sub_y),
        .o_diff   (sub_diff),
        .o_borrow (sub_borrow)
    );

    assign abs_diff  = sub_borrow ? (~sub_diff + SUB_W'(1)) : sub_diff;
    assign half_diff = abs_diff[MAG_W:1];
    assign step_q    = {r_q[MAG_W-2:0], ~sub_borrow};
    assign step_r    = sub_borrow ? sub_x[MAG_W-1:0] : sub_diff[MAG_W-1:0];
    assign last_step = (r_cnt == CNT_W'(MAG_W - 1));

    assign num_abs  = r_n[NUM_W-1] ? NUM_W'(-r_n) : NUM_W'(r_n);
    assign d_abs    = r_d[MAG_W-1] ? MAG_W'(-r_d) : MAG_W'(r_d);
    assign den_norm = (r_d == '0) ? MAG_W'(1) : d_abs;
    assign mag_norm = num_abs[MAG_W-1:0];

    assign mag_ext  = EXT_W'({1'b0, r_mag});
    assign res_ext  = r_neg ? -mag_ext : mag_ext;
    assign den_ext  = EXT_W'(r_den);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_in        = r_in;
        n_n         = r_n;
        n_d         = r_d;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_den       = r_den;
        n_u         = r_u;
        n_v         = r_v;
        n_k         = r_k;
        n_g         = r_g;
        n_q         = r_q;
        n_r         = r_r;
        n_cnt       = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_item;
                    n_state = S_MUL0;
                end
            end
            S_MUL0: begin
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_n     = NUM_W'(prod);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                case (r_in.op)
                    OP_ADD:  n_n = r_n + NUM_W'(prod);
                    OP_SUB:  n_n = r_n - NUM_W'(prod);
                    default: n_n = r_n;
                endcase
                n_state = S_MUL3;
            end
            S_MUL3: begin
                n_d     = prod;
                n_state = S_NORM;
            end
            S_NORM: begin
                if (mag_norm == '0) begin
                    n_neg   = 1'b0;
                    n_mag   = '0;
                    n_den   = MAG_W'(1);
                    n_state = S_DONE;
                end else begin
                    n_neg   = r_n[NUM_W-1] ^ ((r_d != '0) && r_d[MAG_W-1]);
                    n_mag   = mag_norm;
                    n_den   = den_norm;
                    n_u     = mag_norm;
                    n_v     = den_norm;
                    n_k     = '0;
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_u == '0 || r_v == '0) begin
                    n_g     = (r_u | r_v) << r_k;
                    n_q     = r_mag;
                    n_r     = '0;
                    n_cnt   = '0;
                    n_state = S_DIVN;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + CNT_W'(1);
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (!sub_borrow) begin
                    n_u = half_diff;
                end else begin
                    n_v = half_diff;
                end
            end
            S_DIVN: begin
                n_q   = step_q;
                n_r   = step_r;
                n_cnt = r_cnt + CNT_W'(1);
                if (last_step) begin
                    n_mag   = step_q;
                    n_q     = r_den;
                    n_r     = '0;
                    n_cnt   = '0;
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                n_q   = step_q;
                n_r   = step_r;
                n_cnt = r_cnt + CNT_W'(1);
                if (last_step) begin
                    n_den   = step_q;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.res_num = $signed(res_ext[RES_NUM_W-1:0]);
                    n_out.res_den = den_ext[RES_DEN_W-1:0];
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_in  <= n_in;
        r_n   <= n_n;
        r_d   <= n_d;
        r_neg <= n_neg;
        r_mag <= n_mag;
        r_den <= n_den;
        r_u   <= n_u;
        r_v   <= n_v;
        r_k   <= n_k;
        r_g   <= n_g;
        r_q   <= n_q;
        r_r   <= n_r;
        r_cnt <= n_cnt;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `RAU_ASSERT_IMPLY(a_den_nonzero, i_clk, i_rst_n, o_out_valid, o_out_item.res_den != '0, "result denominator is zero")
    `RAU_ASSERT_IMPLY(a_zero_over_one, i_clk, i_rst_n, o_out_valid && (o_out_item.res_num == '0), o_out_item.res_den == RES_DEN_W'(1), "zero result not reduced to 0/1")
    `RAU_ASSERT_IMPLY(a_divisor_nonzero, i_clk, i_rst_n, (r_state == S_DIVN) || (r_state == S_DIVD), r_g != '0, "gcd is zero during division")
    `RAU_ASSERT_NEXT(a_gcd_continues, i_clk, i_rst_n, (r_state == S_GCD) && (r_u != '0) && (r_v != '0), r_state == S_GCD, "gcd left before an operand reached zero")

endmodule
